// File: hw/rtl/pcrm_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pcrm_pkg
// Types, codes and the per-entry match function of the privilege change
// rule matcher.
// ----------------------------------------------------------------------------
package pcrm_pkg;

  localparam int SLOT_W  = 4;
  localparam int COUNT_W = 5;
  localparam int OP_W    = 4;
  localparam int KIND_W  = 2;
  localparam int ID_W    = 32;
  localparam int SEL_W   = 32;
  localparam int PRISON_W = 31;

  // operation codes
  localparam logic [OP_W-1:0] OP_ALL   = 4'd0;
  localparam logic [OP_W-1:0] OP_EXEC  = 4'd1;
  localparam logic [OP_W-1:0] OP_SETID = 4'd2;

  // prison selector codes
  localparam logic [SEL_W-1:0] SEL_SYSTEM      = 32'hFFFF_FFFF;
  localparam logic [SEL_W-1:0] RULE_ANY_PRISON = 32'h0000_0000;

  // identity kinds
  localparam logic [KIND_W-1:0] KIND_UID = 2'd1;
  localparam logic [KIND_W-1:0] KIND_GID = 2'd2;

  // request kinds
  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_CHECK = 1'b1;

  // configuration register indexes
  localparam logic CFG_ENFORCE = 1'b0;
  localparam logic CFG_ACTIVE  = 1'b1;

  typedef struct packed {
    logic [SEL_W-1:0]  sel;
    logic [OP_W-1:0]   op;
    logic [ID_W-1:0]   ident;
    logic [KIND_W-1:0] kind;
  } rule_t;

  typedef struct packed {
    logic                en;
    logic [SLOT_W-1:0]   slot;
    rule_t               rule;
  } wr_t;

  typedef struct packed {
    logic [OP_W-1:0]     check_op;
    logic                in_prison;
    logic [PRISON_W-1:0] caller_prison;
    logic [ID_W-1:0]     real_uid;
    logic [ID_W-1:0]     real_gid;
  } req_t;

  // check transaction walking down the row of cells
  typedef struct packed {
    logic              valid;
    logic              hit;
    logic [SLOT_W-1:0] slot;
    req_t              req;
  } tok_t;

  function automatic logic rule_matches(rule_t r, req_t q);
    logic type_ok;
    logic prison_ok;
    logic id_ok;
    type_ok = (r.op == OP_ALL) ||
              ((q.check_op != OP_EXEC) && (r.op == OP_SETID)) ||
              (r.op == q.check_op);
    if (r.sel == SEL_SYSTEM) begin
      prison_ok = !q.in_prison;
    end else if (r.sel == RULE_ANY_PRISON) begin
      prison_ok = 1'b1;
    end else if (r.sel[SEL_W-1]) begin
      // other negative selectors never match
      prison_ok = 1'b0;
    end else begin
      prison_ok = q.in_prison && ({1'b0, q.caller_prison} == r.sel);
    end
    if (r.kind == KIND_UID) begin
      id_ok = (q.real_uid == r.ident);
    end else if (r.kind == KIND_GID) begin
      id_ok = (q.real_gid == r.ident);
    end else begin
      id_ok = 1'b1;
    end
    return type_ok && prison_ok && id_ok;
  endfunction

endpackage
`default_nettype wire

// File: hw/rtl/pcrm_in_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pcrm_in_if
// Request channel: rule writes and privilege checks.
// ----------------------------------------------------------------------------
interface pcrm_in_if;
  logic               valid;
  logic               ready;
  logic               req_type;
  logic [3:0]         rule_slot;
  logic signed [31:0] rule_prison_sel;
  logic [1:0]         rule_id_kind;
  logic [31:0]        rule_ident;
  logic [3:0]         rule_op;
  logic [3:0]         check_op;
  logic               is_superuser;
  logic               in_prison;
  logic [30:0]        caller_prison;
  logic [31:0]        real_uid;
  logic [31:0]        real_gid;

  modport source (
    output valid, req_type, rule_slot, rule_prison_sel, rule_id_kind, rule_ident,
           rule_op, check_op, is_superuser, in_prison, caller_prison, real_uid,
           real_gid,
    input  ready
  );

  modport sink (
    input  valid, req_type, rule_slot, rule_prison_sel, rule_id_kind, rule_ident,
           rule_op, check_op, is_superuser, in_prison, caller_prison, real_uid,
           real_gid,
    output ready
  );
endinterface
`default_nettype wire

// File: hw/rtl/pcrm_out_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pcrm_out_if
// Result channel: deny decision and lowest matching entry.
// ----------------------------------------------------------------------------
interface pcrm_out_if;
  logic       valid;
  logic       ready;
  logic       denied;
  logic       hit_valid;
  logic [3:0] hit_slot;

  modport source (
    output valid, denied, hit_valid, hit_slot,
    input  ready
  );

  modport sink (
    input  valid, denied, hit_valid, hit_slot,
    output ready
  );
endinterface
`default_nettype wire

// File: hw/rtl/pcrm_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pcrm_cell
// One rule entry: stores its rule and tests the check transaction passing
// through, then registers it for the next cell.
// ----------------------------------------------------------------------------
module pcrm_cell
  import pcrm_pkg::*;
#(
  parameter int IDX = 0
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wr_t                 wr,
  input  wire [COUNT_W-1:0]   active_rules,
  input  tok_t                tok_i,
  output tok_t                tok_o
);

  rule_t rule_r;
  tok_t  tok_r;
  tok_t  tok_nxt;
  logic  entry_on;

  // entries beyond the active count are skipped
  assign entry_on = (32'(active_rules) > 32'(IDX));

  always_ff @(posedge clk) begin
    if (wr.en && (32'(wr.slot) == 32'(IDX))) begin
      rule_r <= wr.rule;
    end
  end

  always_comb begin
    tok_nxt = tok_i;
    if (tok_i.valid && !tok_i.hit && entry_on && rule_matches(rule_r, tok_i.req)) begin
      tok_nxt.hit  = 1'b1;
      tok_nxt.slot = SLOT_W'(IDX);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r.valid <= 1'b0;
    end else begin
      tok_r <= tok_nxt;
    end
  end

  assign tok_o = tok_r;

endmodule
`default_nettype wire

// File: hw/rtl/privilege_change_rule_matcher.sv
`default_nettype none
// ----------------------------------------------------------------------------
// privilege_change_rule_matcher
// Deny-rule table held in a row of cells; a check walks the row one entry
// per cycle and reports the lowest matching entry.
// ----------------------------------------------------------------------------
// path: a check that scans goes through every cell register of the row, then the
// holding stage and the output register; writes, superuser and disabled-policy
// checks skip the row and go straight to the holding stage
// flow: one transaction at a time, the next accepted once the previous result
// moves to the output register
// reset: synchronous active-low; clears control and configuration, rule
// entries hold nothing defined until written
module privilege_change_rule_matcher
  import pcrm_pkg::*;
#(
  parameter int MAX_RULES = 16
) (
  input  wire                clk,
  input  wire                rst_n,
  pcrm_in_if.sink            in_ch,
  pcrm_out_if.source         out_ch,
  input  wire                cfg_we,
  input  wire                cfg_index,
  input  wire [COUNT_W-1:0]  cfg_wdata
);

  logic               enforce_r;
  logic [COUNT_W-1:0] active_r;

  logic               busy_r, busy_nxt;
  logic               done_r, done_nxt;
  logic               done_hit_r, done_hit_nxt;
  logic [SLOT_W-1:0]  done_slot_r, done_slot_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic               out_hit_r, out_hit_nxt;
  logic [SLOT_W-1:0]  out_slot_r, out_slot_nxt;

  logic               in_acc;
  logic               launch;
  logic               out_load;
  wr_t                wr;
  tok_t               inj;
  tok_t               chain [MAX_RULES+1];
  logic [MAX_RULES-1:0] chain_vld;
  tok_t               tail;

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enforce_r <= 1'b0;
      active_r  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ENFORCE: enforce_r <= cfg_wdata[0];
        CFG_ACTIVE:  active_r  <= cfg_wdata;
        default:     ;
      endcase
    end
  end

  assign in_ch.ready = !busy_r;
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign launch      = in_acc && (in_ch.req_type == REQ_CHECK) && enforce_r &&
                       !in_ch.is_superuser;

  always_comb begin
    wr.en         = in_acc && (in_ch.req_type == REQ_WRITE);
    wr.slot       = in_ch.rule_slot;
    wr.rule.sel   = in_ch.rule_prison_sel;
    wr.rule.op    = in_ch.rule_op;
    wr.rule.ident = in_ch.rule_ident;
    wr.rule.kind  = in_ch.rule_id_kind;
  end

  always_comb begin
    inj.valid             = launch;
    inj.hit               = 1'b0;
    inj.slot              = '0;
    inj.req.check_op      = in_ch.check_op;
    inj.req.in_prison     = in_ch.in_prison;
    inj.req.caller_prison = in_ch.caller_prison;
    inj.req.real_uid      = in_ch.real_uid;
    inj.req.real_gid      = in_ch.real_gid;
  end

  assign chain[0] = inj;

  for (genvar k = 0; k < MAX_RULES; k++) begin : g_cell
    pcrm_cell #(
      .IDX (k)
    ) u_cell (
      .clk          (clk),
      .rst_n        (rst_n),
      .wr           (wr),
      .active_rules (active_r),
      .tok_i        (chain[k]),
      .tok_o        (chain[k+1])
    );
    assign chain_vld[k] = chain[k+1].valid;
  end

  assign tail = chain[MAX_RULES];

  // result holding stage ahead of the output register
  assign out_load = done_r && (!out_valid_r || out_ch.ready);

  always_comb begin
    busy_nxt      = busy_r;
    done_nxt      = done_r;
    done_hit_nxt  = done_hit_r;
    done_slot_nxt = done_slot_r;
    if (in_acc) begin
      busy_nxt = 1'b1;
    end else if (out_load) begin
      busy_nxt = 1'b0;
    end
    if (in_acc && !launch) begin
      // write or pass-through check: answer is all zeros
      done_nxt      = 1'b1;
      done_hit_nxt  = 1'b0;
      done_slot_nxt = '0;
    end else if (tail.valid) begin
      done_nxt      = 1'b1;
      done_hit_nxt  = tail.hit;
      done_slot_nxt = tail.slot;
    end else if (out_load) begin
      done_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_hit_nxt   = out_hit_r;
    out_slot_nxt  = out_slot_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
      out_hit_nxt   = done_hit_r;
      out_slot_nxt  = done_slot_r;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      done_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      done_r      <= done_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    done_hit_r  <= done_hit_nxt;
    done_slot_r <= done_slot_nxt;
    out_hit_r   <= out_hit_nxt;
    out_slot_r  <= out_slot_nxt;
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.denied    = out_hit_r;
  assign out_ch.hit_valid = out_hit_r;
  assign out_ch.hit_slot  = out_slot_r;

`ifndef ASSERT_OFF
  // at most one check transaction in the row
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(chain_vld))
    else $error("more than one check in the cell row");

  // the row is empty whenever the block is idle
  a_idle_row_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !busy_r |-> (chain_vld == '0))
    else $error("check in the cell row while idle");

  // a finished result and a walking check never coexist
  a_done_excl: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> (chain_vld == '0) && busy_r)
    else $error("result pending while a check still walks");

  // a launched check comes out of the row after the full walk
  a_walk_len: assert property (@(posedge clk) disable iff (!rst_n)
    launch |-> ##(MAX_RULES) tail.valid)
    else $error("check did not leave the row on time");
`endif

endmodule
`default_nettype wire
